### rtl/tlru_pkg.sv
// Shared constants and types for the two-way LRU cache tag lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package tlru_pkg;

    localparam int NUM_SETS   = 64;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_W     = 32;
    localparam int OFFSET_W   = $clog2(LINE_BYTES);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int BLOCK_W    = ADDR_W - OFFSET_W;
    localparam int TAG_W      = BLOCK_W - SET_W;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [OFFSET_W-1:0] t_offset;
    typedef logic [BLOCK_W-1:0]  t_block;
    typedef logic [SET_W-1:0]    t_set_idx;
    typedef logic [TAG_W-1:0]    t_tag;

    typedef struct packed {
        logic lru;
        t_tag tag1;
        t_tag tag0;
    } t_set_entry;

    typedef struct packed {
        logic way;
        logic miss;
        logic replaced;
        t_tag evicted_tag;
    } t_decision;

endpackage

`default_nettype wire

### rtl/tlru_tag_ram.sv
// Synchronous tag and LRU memory, one entry per set, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tlru_tag_ram
    import tlru_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rd_en,
    input  wire t_set_idx   i_rd_addr,
    output t_set_entry      o_rd_data,
    input  wire logic       i_wr_en,
    input  wire t_set_idx   i_wr_addr,
    input  wire t_set_entry i_wr_data
);

    t_set_entry r_mem [NUM_SETS];
    t_set_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/tlru_resolve.sv
// Hit detection, victim selection and updated set entry for one lookup.
`timescale 1ns / 1ps
`default_nettype none

module tlru_resolve
    import tlru_pkg::*;
(
    input  wire t_tag       i_tag,
    input  wire logic       i_valid0,
    input  wire logic       i_valid1,
    input  wire t_set_entry i_entry,
    output t_decision       o_decision,
    output t_set_entry      o_entry
);

    logic hit0;
    logic hit1;
    logic way;
    logic miss;
    logic replaced;

    always_comb begin
        hit0     = i_valid0 && (i_entry.tag0 == i_tag);
        hit1     = i_valid1 && (i_entry.tag1 == i_tag);
        miss     = !hit0 && !hit1;
        replaced = miss && i_valid0 && i_valid1;

        if (hit0) begin
            way = 1'b0;
        end else if (hit1) begin
            way = 1'b1;
        end else if (!i_valid0) begin
            way = 1'b0;
        end else if (!i_valid1) begin
            way = 1'b1;
        end else begin
            way = i_entry.lru;
        end

        o_decision.way         = way;
        o_decision.miss        = miss;
        o_decision.replaced    = replaced;
        o_decision.evicted_tag = '0;
        if (replaced) begin
            o_decision.evicted_tag = way ? i_entry.tag1 : i_entry.tag0;
        end

        // The way just used becomes most recently used.
        o_entry     = i_entry;
        o_entry.lru = !way;
        if (miss && !way) begin
            o_entry.tag0 = i_tag;
        end
        if (miss && way) begin
            o_entry.tag1 = i_tag;
        end
    end

endmodule

`default_nettype wire

### rtl/two_way_lru_cache_tag_lookup_unit.sv
// Top level of the two-way LRU cache tag lookup unit.
// Address and tag RAM read register on accept, then the result registers at the outputs.
// A new address waits until the previous lookup's tag RAM read and write-back are done.
// The input is stalled while a lookup is in flight or an untaken result would block it.
// Reset clears all valid bits at once and empties the pipeline; tags and LRU bits need no reset.
`timescale 1ns / 1ps
`default_nettype none

module two_way_lru_cache_tag_lookup_unit
    import tlru_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_addr i_address,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_offset   o_byte_offset,
    output t_block    o_block_number,
    output t_set_idx  o_set_index,
    output logic      o_way,
    output t_tag      o_line_tag,
    output logic      o_miss,
    output logic      o_replaced,
    output t_tag      o_evicted_tag
);

    logic          r_busy;
    logic          n_busy;
    t_addr         r_addr;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [NUM_SETS-1:0] r_valid0;
    logic [NUM_SETS-1:0] r_valid1;

    t_offset   r_byte_offset;
    t_block    r_block_number;
    t_set_idx  r_set_index;
    logic      r_way;
    t_tag      r_line_tag;
    logic      r_miss;
    logic      r_replaced;
    t_tag      r_evicted_tag;

    logic       in_accept;
    t_set_idx   cur_set;
    t_tag       cur_tag;
    t_set_entry rd_entry;
    t_set_entry wr_entry;
    t_decision  decision;

    assign o_stall   = r_busy || (r_out_valid && i_stall);
    assign in_accept = i_valid && !o_stall;
    assign cur_set   = r_addr[OFFSET_W +: SET_W];
    assign cur_tag   = r_addr[ADDR_W-1 -: TAG_W];

    tlru_tag_ram u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_address[OFFSET_W +: SET_W]),
        .o_rd_data (rd_entry),
        .i_wr_en   (r_busy),
        .i_wr_addr (cur_set),
        .i_wr_data (wr_entry)
    );

    tlru_resolve u_resolve (
        .i_tag      (cur_tag),
        .i_valid0   (r_valid0[cur_set]),
        .i_valid1   (r_valid1[cur_set]),
        .i_entry    (rd_entry),
        .o_decision (decision),
        .o_entry    (wr_entry)
    );

    always_comb begin
        n_busy      = in_accept;
        n_out_valid = r_out_valid;
        if (r_busy) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid0    <= '0;
            r_valid1    <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (r_busy && decision.miss) begin
                if (decision.way) begin
                    r_valid1[cur_set] <= 1'b1;
                end else begin
                    r_valid0[cur_set] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr <= i_address;
        end
        if (r_busy) begin
            r_byte_offset  <= r_addr[OFFSET_W-1:0];
            r_block_number <= r_addr[ADDR_W-1:OFFSET_W];
            r_set_index    <= cur_set;
            r_way          <= decision.way;
            r_line_tag     <= cur_tag;
            r_miss         <= decision.miss;
            r_replaced     <= decision.replaced;
            r_evicted_tag  <= decision.evicted_tag;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_offset  = r_byte_offset;
    assign o_block_number = r_block_number;
    assign o_set_index    = r_set_index;
    assign o_way          = r_way;
    assign o_line_tag     = r_line_tag;
    assign o_miss         = r_miss;
    assign o_replaced     = r_replaced;
    assign o_evicted_tag  = r_evicted_tag;

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("Lookup stayed busy for more than one cycle.");

    a_busy_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("Finished lookup did not produce a result beat.");

    a_accept_starts_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_busy)
        else $error("Accepted address did not start a lookup.");

    a_replace_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_replaced) |-> o_miss)
        else $error("Replacement reported on a hit.");

    a_evicted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_replaced) |-> (o_evicted_tag == '0))
        else $error("Evicted tag is nonzero without a replacement.");

endmodule

`default_nettype wire
